/* rtl/dtcfd_pkg.sv */
// Shared types and constants for the DTC fault debounce and status block.
// No dependencies; imported by every module under rtl.
package dtcfd_pkg;

	// Result codes carried in the outcome field.
	typedef enum logic [1:0] {
		OUT_FAILED     = 2'd0,
		OUT_PASSED     = 2'd1,
		OUT_INCOMPLETE = 2'd2
	} outcome_t;

	// Configuration register indexes.
	localparam int unsigned CfgIdxW = 3;
	localparam logic [CfgIdxW-1:0] REG_REPORT_ENABLE    = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_FAILED_THRESHOLD = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_PASSED_THRESHOLD = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_WARNING_ENABLE   = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_AUTO_RESTORE     = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_CRITICAL         = 3'd5;
	localparam logic [CfgIdxW-1:0] REG_TROUBLE_CODE     = 3'd6;

	// UDS status byte bit positions.
	localparam int unsigned ST_TF     = 0;
	localparam int unsigned ST_TFTOC  = 1;
	localparam int unsigned ST_CDTC   = 3;
	localparam int unsigned ST_TNCTOC = 6;
	localparam int unsigned ST_WIR    = 7;

	// Masks used on qualification.
	localparam logic [7:0] ST_SET_FAILED = 8'h07;
	localparam logic [7:0] ST_CLR_TNCSLC = 8'hEF;
	localparam logic [7:0] ST_CLR_PASS   = 8'hEE;

	// Configuration register contents.
	typedef struct packed {
		logic              report_enable;
		logic [6:0]        failed_threshold;
		logic signed [7:0] passed_threshold;
		logic              warning_enable;
		logic              auto_restore;
		logic              critical;
		logic [7:0]        trouble_code;
	} cfg_t;

	// One result item.
	typedef struct packed {
		outcome_t   outcome;
		logic [7:0] status_byte;
		logic       store_request;
		logic [7:0] store_code;
	} result_t;

endpackage

/* rtl/dtc_fault_debounce_status.sv */
// Top level of the DTC counter-based debounce and UDS status block.
// Depends on dtcfd_pkg, dtcfd_cfg and dtcfd_core.
//
//  Channel   Direction  Handshake          Payload
//  s_*       in         s_tvalid/s_tready  fault_seen
//  m_*       out        m_tvalid/m_tready  outcome, status_byte, store_request, store_code
//  cfg_*     in         cfg_valid/cfg_ready register index and write data
//
// One sample per cycle unless the output stalls; its result shows in the next cycle.
// The debounce counter and status byte are one register pair updated at each
// input transfer, so the rate is set by that single update path.
// Reset clears counter, status byte and output valid, and loads register defaults.
// While a result waits, a new sample is taken only in the cycle it drains.
module dtc_fault_debounce_status
	import dtcfd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [7:0]         s_tdata,   // [0] fault_seen, [7:1] zero
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [23:0]        m_tdata,   // [1:0] outcome, [9:2] status_byte,
	                                      // [10] store_request, [18:11] store_code
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [7:0]         cfg_data
);

	cfg_t    cfg;
	result_t res;

	dtcfd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	dtcfd_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.fault_seen (s_tdata[0]),
		.res_valid  (m_tvalid),
		.res_ready  (m_tready),
		.res        (res)
	);

	// Pack the result fields, lowest first.
	assign m_tdata = {5'd0, res.store_code, res.store_request, res.status_byte, res.outcome};

	// A store request only comes with a qualified outcome.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res.store_request |-> res.outcome != OUT_INCOMPLETE)
		else $error("store request on incomplete outcome");

	// Without a store the address is zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !res.store_request |-> res.store_code == 8'd0)
		else $error("store code set without store request");

	// A sample taken with reporting off gives incomplete and no store.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !cfg.report_enable |=>
		m_tvalid && res.outcome == OUT_INCOMPLETE && !res.store_request)
		else $error("sample with reporting disabled changed the result");

	// A failed outcome always reports testFailed in the status byte.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res.outcome == OUT_FAILED |-> res.status_byte[ST_TF])
		else $error("failed outcome without testFailed");

endmodule

/* rtl/dtcfd_cfg.sv */
// Configuration register bank for the DTC debounce block.
// Depends on dtcfd_pkg for register indexes and the cfg_t type.
module dtcfd_cfg
	import dtcfd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [7:0]         cfg_data,
	output cfg_t               cfg
);

	cfg_t cfg_q;

	// Writes are always taken; cfg_ready is held high.
	assign cfg_ready = 1'b1;
	assign cfg      = cfg_q;

	// Register write on each transfer; an index beyond the list is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.report_enable    <= 1'b1;
			cfg_q.failed_threshold <= 7'd127;
			cfg_q.passed_threshold <= -8'sd128;
			cfg_q.warning_enable   <= 1'b0;
			cfg_q.auto_restore     <= 1'b0;
			cfg_q.critical         <= 1'b0;
			cfg_q.trouble_code     <= 8'd0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_REPORT_ENABLE:    cfg_q.report_enable    <= cfg_data[0];
				REG_FAILED_THRESHOLD: cfg_q.failed_threshold <= cfg_data[6:0];
				REG_PASSED_THRESHOLD: cfg_q.passed_threshold <= $signed(cfg_data);
				REG_WARNING_ENABLE:   cfg_q.warning_enable   <= cfg_data[0];
				REG_AUTO_RESTORE:     cfg_q.auto_restore     <= cfg_data[0];
				REG_CRITICAL:         cfg_q.critical         <= cfg_data[0];
				REG_TROUBLE_CODE:     cfg_q.trouble_code     <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

/* rtl/dtcfd_core.sv */
// Debounce counter, status byte and result register of the DTC block.
// Depends on dtcfd_pkg for cfg_t, result_t and the status bit layout.
module dtcfd_core
	import dtcfd_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  logic    in_valid,
	output logic    in_ready,
	input  logic    fault_seen,
	output logic    res_valid,
	input  logic    res_ready,
	output result_t res
);

	logic signed [7:0] count_q;
	logic [7:0]        status_q;
	logic              valid_s1;
	result_t           res_s1;

	logic signed [7:0] count_nx;
	logic [7:0]        status_nx;
	logic [7:0]        status_tmp;
	outcome_t          outcome_nx;
	logic              store_nx;
	logic              accept;

	// The result register frees up in the same cycle it is drained.
	assign in_ready  = !valid_s1 || res_ready;
	assign accept    = in_valid && in_ready;
	assign res_valid = valid_s1;
	assign res       = res_s1;

	// Next counter and status for one sample. The critical property does not
	// change the rules: only auto_restore decides a restore after failure.
	always_comb begin
		count_nx   = count_q;
		status_nx  = status_q;
		status_tmp = status_q & ST_CLR_PASS;
		outcome_nx = OUT_INCOMPLETE;
		store_nx   = 1'b0;
		if (cfg.report_enable) begin
			if (fault_seen) begin
				if ($signed({count_q[7], count_q}) < $signed({2'b00, cfg.failed_threshold}))
				begin
					count_nx = count_q[7] ? 8'sd0 : count_q + 8'sd1;
				end else if (!status_q[ST_TF]) begin
					status_nx         = (status_q | ST_SET_FAILED) & ST_CLR_TNCSLC;
					status_nx[ST_WIR] = cfg.warning_enable;
					outcome_nx        = OUT_FAILED;
					store_nx          = 1'b1;
				end
			end else begin
				if (count_q > cfg.passed_threshold) begin
					count_nx = (count_q > 8'sd0) ? 8'sd0 : count_q - 8'sd1;
				end else if (status_q[ST_TF] || status_q[ST_TNCTOC]) begin
					status_nx = status_tmp;
					if (!status_tmp[ST_TFTOC] || cfg.auto_restore) begin
						status_nx          = '0;
						status_nx[ST_CDTC] = 1'b1;
						status_nx[ST_WIR]  = cfg.warning_enable;
						outcome_nx         = OUT_PASSED;
						store_nx           = 1'b1;
					end
				end else begin
					outcome_nx = OUT_PASSED;
					store_nx   = 1'b1;
				end
			end
		end
	end

	// State and result valid update on each input transfer; the valid also clears when the result drains.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			status_q <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				count_q  <= count_nx;
				status_q <= status_nx;
				valid_s1 <= 1'b1;
			end else if (res_ready) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1.outcome       <= outcome_nx;
			res_s1.status_byte   <= status_nx;
			res_s1.store_request <= store_nx;
			res_s1.store_code    <= store_nx ? cfg.trouble_code : 8'd0;
		end
	end

endmodule

/* tb/dtcfd_result_check.sv */
`timescale 1ns / 100ps
// Result checker for the DTC fault debounce and status block: follows every
// transfer, predicts each result and compares it field by field.
// Depends on dtcfd_pkg for the result layout, outcome codes and register indexes.
module dtcfd_result_check
	import dtcfd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	input  logic               s_tready,
	input  logic [7:0]         s_tdata,    // [0] fault_seen
	input  logic               m_tvalid,
	input  logic               m_tready,
	input  logic [23:0]        m_tdata,    // [1:0] outcome, [9:2] status_byte,
	                                       // [10] store_request, [18:11] store_code
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [7:0]         cfg_data,
	output int                 mismatch_count,
	output int                 results_pending
);

	// Predicted copy of the configuration registers.
	logic              report_en;
	logic [6:0]        fail_thr;
	logic signed [7:0] pass_thr;
	logic              warn_en;
	logic              restore_en;
	logic              crit_en;
	logic [7:0]        code_addr;

	// Predicted debounce counter and status byte.
	logic signed [7:0] debounce;
	logic [7:0]        dtc_status;

	result_t expected_q[$];
	result_t want;
	int      err_total;

	assign mismatch_count = err_total;

	task automatic report_mismatch(input string field, input int got, input int exp_val);
		err_total++;
		$display("MISMATCH at %0t: %s got 0x%0h, wanted 0x%0h", $time, field, got, exp_val);
	endtask

	// Register write, with the same masking as the real register widths.
	task automatic write_register(input logic [CfgIdxW-1:0] idx, input logic [7:0] data);
		case (idx)
			REG_REPORT_ENABLE: begin
				report_en = data[0];
			end
			REG_FAILED_THRESHOLD: begin
				fail_thr = data[6:0];
			end
			REG_PASSED_THRESHOLD: begin
				pass_thr = data;
			end
			REG_WARNING_ENABLE: begin
				warn_en = data[0];
			end
			REG_AUTO_RESTORE: begin
				restore_en = data[0];
			end
			REG_CRITICAL: begin
				crit_en = data[0];
			end
			REG_TROUBLE_CODE: begin
				code_addr = data;
			end
			default: begin
			end
		endcase
	endtask

	// One test sample through the debounce counter and the status byte rules.
	// The critical flag never changes the result: without auto restore a failure
	// seen this operation cycle is never restored.
	function automatic result_t debounce_sample(input logic fault);
		result_t    r;
		int         cnt;
		int         fthr;
		int         pthr;
		logic [7:0] s;
		r.outcome = OUT_INCOMPLETE;
		r.store_request = 1'b0;
		cnt = debounce;
		fthr = fail_thr;
		pthr = pass_thr;
		if (report_en) begin
			if (fault) begin
				if (cnt < fthr) begin
					cnt = (cnt < 0) ? 0 : cnt + 1;
				end else if (!dtc_status[ST_TF]) begin
					s = (dtc_status | ST_SET_FAILED) & ST_CLR_TNCSLC;
					s[ST_WIR] = warn_en;
					dtc_status = s;
					r.outcome = OUT_FAILED;
					r.store_request = 1'b1;
				end
			end else begin
				if (cnt > pthr) begin
					cnt = (cnt > 0) ? 0 : cnt - 1;
				end else if (dtc_status[ST_TF] || dtc_status[ST_TNCTOC]) begin
					dtc_status = dtc_status & ST_CLR_PASS;
					if (!dtc_status[ST_TFTOC] || restore_en) begin
						s = 8'h00;
						s[ST_CDTC] = 1'b1;
						s[ST_WIR] = warn_en;
						dtc_status = s;
						r.outcome = OUT_PASSED;
						r.store_request = 1'b1;
					end
				end else begin
					r.outcome = OUT_PASSED;
					r.store_request = 1'b1;
				end
			end
			if (cnt < -128) cnt = -128;
			if (cnt > 127) cnt = 127;
			debounce = cnt[7:0];
		end
		r.status_byte = dtc_status;
		r.store_code = r.store_request ? code_addr : 8'h00;
		return r;
	endfunction

	// Compare result transfers first, then take register writes and new samples.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			report_en = 1'b1;
			fail_thr = 7'd127;
			pass_thr = -8'sd128;
			warn_en = 1'b0;
			restore_en = 1'b0;
			crit_en = 1'b0;
			code_addr = 8'h00;
			debounce = 8'sd0;
			dtc_status = 8'h00;
			expected_q.delete();
			results_pending <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_q.size() == 0) begin
					report_mismatch("result with none expected", m_tdata, 0);
				end else begin
					want = expected_q.pop_front();
					if (m_tdata[1:0] !== want.outcome)
						report_mismatch("outcome", m_tdata[1:0], want.outcome);
					if (m_tdata[9:2] !== want.status_byte)
						report_mismatch("status_byte", m_tdata[9:2], want.status_byte);
					if (m_tdata[10] !== want.store_request)
						report_mismatch("store_request", m_tdata[10], want.store_request);
					if (m_tdata[18:11] !== want.store_code)
						report_mismatch("store_code", m_tdata[18:11], want.store_code);
				end
			end
			if (cfg_valid && cfg_ready) begin
				write_register(cfg_index, cfg_data);
			end
			if (s_tvalid && s_tready) begin
				expected_q.push_back(debounce_sample(s_tdata[0]));
			end
			results_pending <= expected_q.size();
		end
	end

endmodule

/* tb/tb_dtc_fault_debounce_status.sv */
`timescale 1ns / 100ps
// Top of the testbench for dtc_fault_debounce_status: clock, reset, sample and
// register stimulus, receiver stalls and the verdict. Depends on dtcfd_pkg and dtcfd_result_check.
module tb_dtc_fault_debounce_status;
	import dtcfd_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int LONG_HOLD = 300;
	localparam logic [CfgIdxW-1:0] REG_UNUSED = 3'd7;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               s_tvalid;
	logic               s_tready;
	logic [7:0]         s_tdata;   // [0] fault_seen, [7:1] zero
	logic               m_tvalid;
	logic               m_tready;
	logic [23:0]        m_tdata;   // [1:0] outcome, [9:2] status_byte,
	                               // [10] store_request, [18:11] store_code
	logic               cfg_valid;
	logic               cfg_ready;
	logic [CfgIdxW-1:0] cfg_index;
	logic [7:0]         cfg_data;

	int mismatch_count;
	int results_pending;
	int cycle_count = 0;

	// Random idling on each side, and the request for one long receiver hold.
	bit idle_on = 1'b1;
	bit stall_on = 1'b1;
	bit hold_req = 1'b0;

	int         fthr;
	int         pthr;
	int         n_items;
	logic [7:0] en_d;
	logic [7:0] wr_d;
	logic [7:0] ar_d;
	logic [7:0] cr_d;
	logic [7:0] code_d;

	dtc_fault_debounce_status DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	dtcfd_result_check u_result_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.mismatch_count  (mismatch_count),
		.results_pending (results_pending)
	);

	// 8 ns clock.
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Receiver: random short stalls, one long hold on request, none late in the run.
	initial begin
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_req = 1'b0;
			end else if (stall_on && $urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 4)) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
		end
	end

	// One sample transfer, sometimes after a short idle gap.
	task automatic send_sample(input logic fault);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {7'b0, fault};
		do @(posedge clk); while (!s_tready);
	endtask

	// Stop sending and wait until every expected result has been seen.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		do @(posedge clk); while (results_pending != 0);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [7:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// Full register set, written only once the block is idle.
	task automatic set_config(input logic [7:0] en, input logic [7:0] f_thr,
			input logic [7:0] p_thr, input logic [7:0] warn, input logic [7:0] restore,
			input logic [7:0] crit, input logic [7:0] code);
		drain_results();
		write_reg(REG_REPORT_ENABLE, en);
		write_reg(REG_FAILED_THRESHOLD, f_thr);
		write_reg(REG_PASSED_THRESHOLD, p_thr);
		write_reg(REG_WARNING_ENABLE, warn);
		write_reg(REG_AUTO_RESTORE, restore);
		write_reg(REG_CRITICAL, crit);
		write_reg(REG_TROUBLE_CODE, code);
		cfg_valid <= 1'b0;
	endtask

	// Runs of equal samples long enough to reach or just miss the thresholds,
	// mixed with short noisy stretches.
	task automatic run_phase(input int count, input int f_thr, input int p_thr);
		int   sent;
		int   len;
		int   mode;
		logic fault;
		logic bit_now;
		sent = 0;
		while (sent < count) begin
			fault = 1'($urandom_range(0, 1));
			mode = $urandom_range(0, 5);
			if (mode == 0)
				len = $urandom_range(1, 3);
			else if (fault)
				len = f_thr + $urandom_range(1, 3);
			else
				len = ((p_thr < 0) ? -p_thr : 0) + $urandom_range(1, 4);
			for (int i = 0; i < len && sent < count; i++) begin
				bit_now = (mode == 0) ? 1'($urandom_range(0, 1)) : fault;
				send_sample(bit_now);
				sent++;
			end
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= 8'h00;
		cfg_valid <= 1'b0;
		cfg_index <= REG_REPORT_ENABLE;
		cfg_data <= 8'h00;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Default registers after reset: the counter only moves.
		send_sample(1'b1);
		send_sample(1'b0);

		// Small thresholds: qualify failed, repeat while failed, then a pass that
		// cannot restore without auto restore, then a plain pass.
		set_config(8'h01, 8'h02, 8'hFE, 8'h01, 8'h00, 8'h01, 8'hA5);
		repeat (4) send_sample(1'b1);
		repeat (5) send_sample(1'b0);

		// Zero thresholds with auto restore: a fault that only clears the negative counter, a plain pass, then a fail.
		set_config(8'h01, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00);
		send_sample(1'b1);
		send_sample(1'b0);
		send_sample(1'b1);

		// Reporting disabled: incomplete and no state change.
		set_config(8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h01, 8'h3C);
		send_sample(1'b1);
		send_sample(1'b0);

		// Unused register index, masked failed threshold and a positive passed threshold.
		set_config(8'h01, 8'hFF, 8'h05, 8'h01, 8'h00, 8'h00, 8'hFF);
		write_reg(REG_UNUSED, 8'h5A);
		cfg_valid <= 1'b0;
		send_sample(1'b1);
		send_sample(1'b0);
		send_sample(1'b0);
		send_sample(1'b0);

		// Random phases, each with a fresh register set.
		for (int ph = 0; ph < 16; ph++) begin
			if (ph >= 13) begin
				idle_on = 1'b0;
				stall_on = 1'b0;
			end
			en_d = {7'($urandom), 1'b1};
			wr_d = {7'($urandom), 1'($urandom)};
			ar_d = {7'($urandom), 1'($urandom)};
			cr_d = {7'($urandom), 1'($urandom)};
			code_d = 8'($urandom);
			n_items = 60;
			case (ph)
				0: begin
					fthr = 127;
					pthr = -128;
					n_items = 600;
					wr_d = 8'h01;
					ar_d = 8'h01;
					cr_d = 8'h01;
					code_d = 8'hFF;
				end
				1: begin
					fthr = 0;
					pthr = 0;
					n_items = 80;
					wr_d = 8'h00;
					ar_d = 8'h00;
					cr_d = 8'h00;
					code_d = 8'h00;
				end
				default: begin
					fthr = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
						: $urandom_range(0, 6);
					if ($urandom_range(0, 7) == 0)
						pthr = $urandom_range(1, 127);
					else if ($urandom_range(0, 3) == 0)
						pthr = -$urandom_range(0, 128);
					else
						pthr = -$urandom_range(0, 6);
					if (ph == 5 || ph == 10) begin
						en_d[0] = 1'b0;
						n_items = 20;
					end
				end
			endcase
			set_config(en_d, {1'($urandom), 7'(fthr)}, 8'(pthr), wr_d, ar_d, cr_d, code_d);
			if (ph == 3) hold_req = 1'b1;
			run_phase(n_items, fthr, pthr);
		end

		drain_results();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && results_pending == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

/* sim.f */
rtl/dtcfd_pkg.sv
rtl/dtcfd_cfg.sv
rtl/dtcfd_core.sv
rtl/dtc_fault_debounce_status.sv
tb/dtcfd_result_check.sv
tb/tb_dtc_fault_debounce_status.sv
